FILE: rtl/aat_pkg.sv
// aat_pkg: shared types, opcodes and helpers for the aabb affine transform
// no dependencies; imported by every module in rtl/
package aat_pkg;

  localparam int WORD_W   = 32;
  localparam int PROD_W   = 2 * WORD_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int AXES     = 3;
  localparam int COLS     = 4;
  localparam int IN_WORDS = 10;
  localparam int COEF_POS = 0;
  localparam int LO_POS   = 4;
  localparam int HI_POS   = 7;
  localparam int IN_DATA_W  = IN_WORDS * WORD_W;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 2 * AXES * WORD_W;
  localparam int OUT_USER_W = 1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_BOX     = 2'd1,
    OP_INVALID = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_Z = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef word_t [AXES-1:0][COLS-1:0] matrix_t;

  typedef struct packed {
    op_t                    op;
    logic [1:0]             row;
    word_t [COLS-1:0]       coef;
    word_t [AXES-1:0]       lo;
    word_t [AXES-1:0]       hi;
  } s1_t;

  typedef struct packed {
    prod_t [AXES-1:0][AXES-1:0] plo;
    prod_t [AXES-1:0][AXES-1:0] phi;
    word_t [AXES-1:0]           cw;
    logic                       bv;
  } s2_t;

  typedef struct packed {
    prod_t [AXES-1:0][AXES-1:0] tmin;
    prod_t [AXES-1:0][AXES-1:0] tmax;
    word_t [AXES-1:0]           cw;
    logic                       bv;
  } s3_t;

  typedef struct packed {
    word_t [AXES-1:0] wmin;
    word_t [AXES-1:0] wmax;
    logic             bv;
  } res_t;

  function automatic prod_t mul_ww(word_t a, word_t b);
    prod_t ea;
    prod_t eb;
    ea = prod_t'(a);
    eb = prod_t'(b);
    return ea * eb;
  endfunction

endpackage

FILE: rtl/aat_prod_stage.sv
// aat_prod_stage: corner products of each matrix row with box min and max
// depends on aat_pkg
module aat_prod_stage
  import aat_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  s1_t     up_data,
  input  matrix_t matrix,
  output logic    dn_valid,
  input  logic    dn_ready,
  output s2_t     dn_data
);

  logic v_r;
  s2_t  data_r;
  s2_t  data_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt.bv = (up_data.op == OP_BOX);
    for (int a = 0; a < AXES; a++) begin
      data_nxt.cw[a] = matrix[a][COLS-1];
      for (int c = 0; c < AXES; c++) begin
        data_nxt.plo[a][c] = mul_ww(matrix[a][c], up_data.lo[c]);
        data_nxt.phi[a][c] = mul_ww(matrix[a][c], up_data.hi[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: rtl/aat_sel_stage.sv
// aat_sel_stage: fraction drop on each product and per-term min/max pick
// depends on aat_pkg
module aat_sel_stage
  import aat_pkg::*;
#(
  parameter int FRAC_BITS = 16
)(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  s2_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output s3_t  dn_data
);

  logic v_r;
  s3_t  data_r;
  s3_t  data_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_comb begin
    prod_t tl;
    prod_t th;
    data_nxt.bv = up_data.bv;
    data_nxt.cw = up_data.cw;
    for (int a = 0; a < AXES; a++) begin
      for (int c = 0; c < AXES; c++) begin
        tl = $signed(up_data.plo[a][c]) >>> FRAC_BITS;
        th = $signed(up_data.phi[a][c]) >>> FRAC_BITS;
        data_nxt.tmin[a][c] = (tl < th) ? tl : th;
        data_nxt.tmax[a][c] = (tl < th) ? th : tl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: rtl/aat_sum_stage.sv
// aat_sum_stage: per-axis sums with translation, saturation, output register
// depends on aat_pkg
module aat_sum_stage
  import aat_pkg::*;
#(
  parameter int COORD_WIDTH = 32
)(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  s3_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output res_t dn_data
);

  localparam int   SAT_BITS = (COORD_WIDTH < WORD_W) ? COORD_WIDTH : WORD_W;
  localparam sum_t SAT_HI   = sum_t'((sum_t'(1) <<< (SAT_BITS - 1)) - sum_t'(1));
  localparam sum_t SAT_LO   = -SAT_HI - sum_t'(1);

  logic v_r;
  res_t data_r;
  res_t data_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  function automatic word_t sat_w(sum_t s);
    sum_t c;
    c = (s > SAT_HI) ? SAT_HI : ((s < SAT_LO) ? SAT_LO : s);
    return c[WORD_W-1:0];
  endfunction

  always_comb begin
    sum_t smin;
    sum_t smax;
    data_nxt.bv = up_data.bv;
    for (int a = 0; a < AXES; a++) begin
      smin = sum_t'($signed(up_data.cw[a]));
      smax = sum_t'($signed(up_data.cw[a]));
      for (int c = 0; c < AXES; c++) begin
        smin = smin + sum_t'($signed(up_data.tmin[a][c]));
        smax = smax + sum_t'($signed(up_data.tmax[a][c]));
      end
      data_nxt.wmin[a] = up_data.bv ? sat_w(smin) : '0;
      data_nxt.wmax[a] = up_data.bv ? sat_w(smax) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: rtl/aabb_affine_transform.sv
// Transforms a fixed-point axis-aligned box by the top three rows of a stored
// affine matrix. A row-load beat writes one matrix row and gives no result; a
// box beat gives one result: the world box as per-axis min and max over its
// eight corners, each product floored and each sum saturated. An invalid-box
// beat gives zeros with box_valid clear. The block takes one beat per cycle
// while the output is not held off; a result passes through four registers (input
// register, product stage with 18 multipliers, min/max pick, sum and saturate);
// each stage holds its beat under backpressure, so bubbles absorb stalls.
// depends on aat_pkg, aat_prod_stage, aat_sel_stage, aat_sum_stage
module aabb_affine_transform
  import aat_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // coef_x, coef_y, coef_z, coef_w, min_x, min_y, min_z, max_x, max_y, max_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op, row_index
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // world_min_x, world_min_y, world_min_z, world_max_x, world_max_y, world_max_z
  output logic [OUT_DATA_W-1:0] out_tdata,
  // box_valid
  output logic [OUT_USER_W-1:0] out_tuser
);

  logic    s1_v_r;
  s1_t     s1_r;
  s1_t     s1_nxt;
  matrix_t matrix_r;
  logic    s1_fwd;
  logic    s1_leave;
  logic    prod_ready;
  logic    s2_valid;
  logic    sel_ready;
  s2_t     s2_data;
  logic    s3_valid;
  logic    sum_ready;
  s3_t     s3_data;
  res_t    res;

  always_comb begin
    s1_nxt.op  = op_t'(in_tuser[1:0]);
    s1_nxt.row = in_tuser[3:2];
    for (int c = 0; c < COLS; c++) begin
      s1_nxt.coef[c] = in_tdata[WORD_W*(COEF_POS+c) +: WORD_W];
    end
    for (int a = 0; a < AXES; a++) begin
      s1_nxt.lo[a] = in_tdata[WORD_W*(LO_POS+a) +: WORD_W];
      s1_nxt.hi[a] = in_tdata[WORD_W*(HI_POS+a) +: WORD_W];
    end
  end

  always_comb begin
    unique case (s1_r.op)
      OP_BOX, OP_INVALID: s1_fwd = 1'b1;
      OP_LOAD, OP_NOP:    s1_fwd = 1'b0;
      default:            s1_fwd = 1'b0;
    endcase
  end

  // loads and no-ops retire in the input register
  assign s1_leave  = s1_fwd ? prod_ready : 1'b1;
  assign in_tready = !s1_v_r || s1_leave;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= '0;
    end else if (s1_v_r && (s1_r.op == OP_LOAD)) begin
      unique case (s1_r.row)
        ROW_X:   matrix_r[0] <= s1_r.coef;
        ROW_Y:   matrix_r[1] <= s1_r.coef;
        ROW_Z:   matrix_r[2] <= s1_r.coef;
        default: matrix_r    <= matrix_r;
      endcase
    end
  end

  aat_prod_stage u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_v_r && s1_fwd),
    .up_ready (prod_ready),
    .up_data  (s1_r),
    .matrix   (matrix_r),
    .dn_valid (s2_valid),
    .dn_ready (sel_ready),
    .dn_data  (s2_data)
  );

  aat_sel_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (sel_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (sum_ready),
    .dn_data  (s3_data)
  );

  aat_sum_stage #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (sum_ready),
    .up_data  (s3_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res)
  );

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      out_tdata[WORD_W*a +: WORD_W]        = res.wmin[a];
      out_tdata[WORD_W*(AXES+a) +: WORD_W] = res.wmax[a];
    end
    out_tuser[0] = res.bv;
  end

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("invalid box beat carries nonzero coordinates");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      ($signed(res.wmin[0]) <= $signed(res.wmax[0])) &&
      ($signed(res.wmin[1]) <= $signed(res.wmax[1])) &&
      ($signed(res.wmin[2]) <= $signed(res.wmax[2])))
    else $error("world box min above max");

  a_row_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && (s1_r.op == OP_LOAD) && (s1_r.row == ROW_Y) |=>
      matrix_r[1] == $past(s1_r.coef))
    else $error("row load not written to matrix");

  a_load_no_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && (s1_r.op == OP_LOAD) |-> in_tready)
    else $error("row load stalled in input register");

endmodule

FILE: dv/aabb_world_box_checker.sv
`timescale 1ns / 1ps
// aabb_world_box_checker: watches both streams of the aabb affine transform, keeps its own copy
// of the matrix rows, predicts the world box of every box beat and compares each result beat
// depends on aat_pkg
module aabb_world_box_checker
  import aat_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [OUT_USER_W-1:0] out_tuser,
  output int                    errors,
  output int                    pending,
  output int                    boxes_checked
);

  localparam int     SAT_W  = (COORD_WIDTH < WORD_W) ? COORD_WIDTH : WORD_W;
  localparam longint SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
  localparam longint SAT_LO = -SAT_HI - 64'sd1;

  word_t row_coefs [AXES][COLS];
  res_t  world_boxes_q [$];
  string axis_names [AXES] = '{"x", "y", "z"};

  initial begin
    errors        = 0;
    pending       = 0;
    boxes_checked = 0;
  end

  task automatic report(input string msg);
    $display("%0t ERROR %s", $time, msg);
    errors++;
  endtask

  // one transformed corner coordinate: floored products, exact sum, one saturation
  function automatic word_t corner_coord(input int axis, input word_t px, input word_t py,
                                         input word_t pz);
    longint acc;
    acc = (longint'(row_coefs[axis][0]) * longint'(px)) >>> FRAC_BITS;
    acc += (longint'(row_coefs[axis][1]) * longint'(py)) >>> FRAC_BITS;
    acc += (longint'(row_coefs[axis][2]) * longint'(pz)) >>> FRAC_BITS;
    acc += longint'(row_coefs[axis][3]);
    if (acc > SAT_HI) acc = SAT_HI;
    if (acc < SAT_LO) acc = SAT_LO;
    return word_t'(acc);
  endfunction

  function automatic res_t transform_box(input word_t [IN_WORDS-1:0] w);
    res_t  box;
    word_t lo_v [AXES];
    word_t hi_v [AXES];
    word_t v;
    word_t px;
    word_t py;
    word_t pz;
    for (int k = 0; k < 8; k++) begin
      px = k[0] ? w[HI_POS]     : w[LO_POS];
      py = k[1] ? w[HI_POS + 1] : w[LO_POS + 1];
      pz = k[2] ? w[HI_POS + 2] : w[LO_POS + 2];
      for (int a = 0; a < AXES; a++) begin
        v = corner_coord(a, px, py, pz);
        if (k == 0 || v < lo_v[a]) lo_v[a] = v;
        if (k == 0 || v > hi_v[a]) hi_v[a] = v;
      end
    end
    for (int a = 0; a < AXES; a++) begin
      box.wmin[a] = lo_v[a];
      box.wmax[a] = hi_v[a];
    end
    box.bv = 1'b1;
    return box;
  endfunction

  task automatic take_input();
    word_t [IN_WORDS-1:0] w;
    op_t                  op;
    logic [1:0]           row;
    res_t                 cleared;
    w       = in_tdata;
    op      = op_t'(in_tuser[1:0]);
    row     = in_tuser[3:2];
    cleared = '0;
    case (op)
      OP_LOAD: begin
        if (row <= ROW_Z) begin
          for (int c = 0; c < COLS; c++) row_coefs[row][c] = w[COEF_POS + c];
        end
      end
      OP_BOX:     world_boxes_q.push_back(transform_box(w));
      OP_INVALID: world_boxes_q.push_back(cleared);
      default: ;
    endcase
  endtask

  task automatic check_box();
    res_t  want;
    word_t got;
    if (world_boxes_q.size() == 0) begin
      report("result beat with no box outstanding");
      return;
    end
    want = world_boxes_q.pop_front();
    boxes_checked++;
    for (int a = 0; a < AXES; a++) begin
      got = out_tdata[a * WORD_W +: WORD_W];
      if (got !== want.wmin[a]) begin
        report($sformatf("box %0d world_min_%s: got %0d, expected %0d", boxes_checked,
                         axis_names[a], got, $signed(want.wmin[a])));
      end
      got = out_tdata[(AXES + a) * WORD_W +: WORD_W];
      if (got !== want.wmax[a]) begin
        report($sformatf("box %0d world_max_%s: got %0d, expected %0d", boxes_checked,
                         axis_names[a], got, $signed(want.wmax[a])));
      end
    end
    if (out_tuser[0] !== want.bv) begin
      report($sformatf("box %0d box_valid: got %b, expected %b", boxes_checked, out_tuser[0],
                       want.bv));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (row_coefs[r, c]) row_coefs[r][c] = '0;
      world_boxes_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_box();
      if (in_tvalid && in_tready) take_input();
    end
    pending <= world_boxes_q.size();
  end

endmodule

FILE: dv/aabb_affine_transform_tb.sv
`timescale 1ns / 1ps
// aabb_affine_transform_tb: drives row loads, boxes and invalid boxes with random idling on both
// streams and gives the verdict; checking is done by aabb_world_box_checker
// depends on aat_pkg, aabb_affine_transform and aabb_world_box_checker
module aabb_affine_transform_tb;
  import aat_pkg::*;

  localparam int         COORD_WIDTH  = 32;
  localparam int         FRAC_BITS    = 16;
  localparam int         RANDOM_ITEMS = 1100;
  localparam int         PHASES       = 4;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         CYCLE_LIMIT  = 600000;
  localparam logic [1:0] ROW_NONE     = 2'd3;
  localparam word_t      ONE          = 32'sh0001_0000;
  localparam word_t      W_MAX        = 32'sh7fff_ffff;
  localparam word_t      W_MIN        = 32'sh8000_0000;

  typedef word_t [IN_WORDS-1:0] beat_words_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  int errors;
  int pending;
  int boxes_checked;
  int n_loads;
  int n_boxes;
  int n_invalid;
  int n_ignored;
  bit quiet;
  bit hold_off_req;

  aabb_affine_transform #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  aabb_world_box_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) box_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .errors       (errors),
    .pending      (pending),
    .boxes_checked(boxes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t rand_word();
    word_t v;
    case ($urandom_range(0, 7))
      0, 1: v = word_t'($urandom);
      2: begin
        case ($urandom_range(0, 5))
          0:       v = W_MIN;
          1:       v = W_MAX;
          2:       v = ONE;
          3:       v = -ONE;
          4:       v = -1;
          default: v = '0;
        endcase
      end
      default: v = word_t'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
    endcase
    return v;
  endfunction

  function automatic beat_words_t random_words();
    beat_words_t w;
    for (int i = 0; i < IN_WORDS; i++) w[i] = word_t'($urandom);
    return w;
  endfunction

  function automatic beat_words_t row_beat(input word_t cx, input word_t cy, input word_t cz,
                                           input word_t cw);
    beat_words_t w;
    w = random_words();
    w[COEF_POS]     = cx;
    w[COEF_POS + 1] = cy;
    w[COEF_POS + 2] = cz;
    w[COEF_POS + 3] = cw;
    return w;
  endfunction

  function automatic beat_words_t box_beat(input word_t lx, input word_t ly, input word_t lz,
                                           input word_t hx, input word_t hy, input word_t hz);
    beat_words_t w;
    w = random_words();
    w[LO_POS]     = lx;
    w[LO_POS + 1] = ly;
    w[LO_POS + 2] = lz;
    w[HI_POS]     = hx;
    w[HI_POS + 1] = hy;
    w[HI_POS + 2] = hz;
    return w;
  endfunction

  function automatic beat_words_t random_row();
    return row_beat(rand_word(), rand_word(), rand_word(), rand_word());
  endfunction

  // mostly ordered min/max per axis, sometimes swapped
  function automatic beat_words_t random_box();
    beat_words_t w;
    word_t a;
    word_t b;
    w = random_words();
    for (int i = 0; i < AXES; i++) begin
      a = rand_word();
      b = rand_word();
      if ($urandom_range(0, 9) < 7 && a > b) begin
        w[LO_POS + i] = b;
        w[HI_POS + i] = a;
      end else begin
        w[LO_POS + i] = a;
        w[HI_POS + i] = b;
      end
    end
    return w;
  endfunction

  task automatic send_beat(input op_t op, input logic [1:0] row, input beat_words_t w);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= {row, op};
    do @(posedge clk); while (!in_tready);
    case (op)
      OP_LOAD:    if (row == ROW_NONE) n_ignored++; else n_loads++;
      OP_BOX:     n_boxes++;
      OP_INVALID: n_invalid++;
      default:    n_ignored++;
    endcase
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : sink
    bit level;
    int run;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        level        = 1'b0;
        run          = HOLD_CYCLES;
      end else if (quiet) begin
        level = 1'b1;
        run   = 1;
      end else begin
        level = ($urandom_range(0, 3) != 0);
        run   = level ? $urandom_range(1, 16) : 1 + pick_gap();
      end
      out_tready <= level;
      repeat (run) @(posedge clk);
    end
  end

  initial begin : stimulus
    int counted;
    int r;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= '0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    n_loads      = 0;
    n_boxes      = 0;
    n_invalid    = 0;
    n_ignored    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty matrix after reset maps every corner to zero
    send_beat(OP_BOX, ROW_X, box_beat(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX));
    send_beat(OP_INVALID, ROW_Y, random_words());
    send_beat(OP_NOP, ROW_Z, random_words());
    // a load to row index 3 leaves the matrix alone
    send_beat(OP_LOAD, ROW_NONE, row_beat(W_MAX, W_MAX, W_MAX, W_MAX));
    send_beat(OP_BOX, ROW_NONE, box_beat(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    // identity with translation
    send_beat(OP_LOAD, ROW_X, row_beat(ONE, '0, '0, 3 * ONE));
    send_beat(OP_LOAD, ROW_Y, row_beat('0, ONE, '0, -5 * ONE));
    send_beat(OP_LOAD, ROW_Z, row_beat('0, '0, ONE, ONE / 2));
    send_beat(OP_BOX, ROW_X, box_beat(-2 * ONE, -3 * ONE, -4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE));
    // min above max on y
    send_beat(OP_BOX, ROW_Y, box_beat(ONE, 9 * ONE, -ONE, 2 * ONE, -9 * ONE, ONE));
    send_beat(OP_BOX, ROW_Z, box_beat(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX));
    // full-scale rows push the sums into both saturation limits
    send_beat(OP_LOAD, ROW_X, row_beat(W_MAX, W_MAX, W_MAX, W_MAX));
    send_beat(OP_LOAD, ROW_Y, row_beat(W_MIN, W_MIN, W_MIN, W_MIN));
    send_beat(OP_LOAD, ROW_Z, row_beat(W_MIN, W_MAX, -1, W_MIN));
    send_beat(OP_BOX, ROW_X, box_beat(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX));
    send_beat(OP_BOX, ROW_NONE, box_beat(1, 1, 1, 2, 2, 2));
    // tiny negative products floor toward minus infinity
    send_beat(OP_LOAD, ROW_Y, row_beat(-1, -1, -1, '0));
    send_beat(OP_BOX, ROW_Y, box_beat(1, 2, 3, 4, 5, 6));
    send_beat(OP_INVALID, ROW_NONE, random_words());
    send_beat(OP_BOX, ROW_Z, random_box());
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      quiet = (phase == 1);
      if (phase == 2) hold_off_req = 1'b1;
      counted = 0;
      while (counted < RANDOM_ITEMS / PHASES) begin
        r = $urandom_range(0, 99);
        if (r < 14) begin
          send_beat(OP_LOAD, 2'($urandom_range(ROW_X, ROW_Z)), random_row());
          counted++;
        end else if (r < 16) begin
          send_beat(OP_LOAD, ROW_NONE, random_row());
        end else if (r < 20) begin
          send_beat(OP_NOP, 2'($urandom_range(0, 3)), random_words());
        end else if (r < 30) begin
          send_beat(OP_INVALID, 2'($urandom_range(0, 3)), random_words());
          counted++;
        end else begin
          send_beat(OP_BOX, 2'($urandom_range(0, 3)), random_box());
          counted++;
        end
      end
      wait_drained();
    end
    quiet = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d row loads, %0d boxes, %0d invalid boxes, %0d ignored beats",
             n_loads, n_boxes, n_invalid, n_ignored);
    $display("%0d result beats compared, including a %0d-cycle output hold-off",
             boxes_checked, HOLD_CYCLES);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
